### rtl/dqms_pkg.sv
// Shared definitions for the double-ended queue with match search.
// Holds request codes, status codes, the register map, the sequencer states
// and the store access struct. Depends on nothing.
package dqms_pkg;

    // Request codes carried in the mode field.
    localparam logic [3:0] MODE_ADD_FRONT    = 4'd0;
    localparam logic [3:0] MODE_ADD_BACK     = 4'd1;
    localparam logic [3:0] MODE_REMOVE_FRONT = 4'd2;
    localparam logic [3:0] MODE_REMOVE_BACK  = 4'd3;
    localparam logic [3:0] MODE_PEEK_FRONT   = 4'd4;
    localparam logic [3:0] MODE_PEEK_BACK    = 4'd5;
    localparam logic [3:0] MODE_FIND         = 4'd6;
    localparam logic [3:0] MODE_REMOVE_MATCH = 4'd7;
    localparam logic [3:0] MODE_CLEAR        = 4'd8;

    // Register index, taken from address bit 2.
    localparam logic REG_IDX_MATCH_MASK = 1'b0;

    // Reset value of the match mask.
    localparam logic [31:0] MATCH_MASK_RESET = 32'hFFFF_FFFF;

    // Status codes returned with every result word.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_RDATA,
        S_WALK,
        S_DONE
    } state_t;

    // Store access strobes.
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

### rtl/deque_with_match_search.sv
// Bounded double-ended queue of item words with find and remove-matching
// requests, kept in a ring store with a registered read port. Each accepted
// request gives exactly one result word. Find and remove matching walk the
// held entries through the store's single read port, one entry per cycle,
// and find stops at its first match. A new request is taken once the
// previous one has placed its result in the output register, even while that
// word still waits to be taken. The match mask register (address 0) selects
// the bits compared; it should be written only while the queue is idle.
// Depends on dqms_pkg, dqms_ctrl and dqms_ram.
module deque_with_match_search #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [3:0]                      mode,
    input  logic [ITEM_WIDTH-1:0]           item_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ITEM_WIDTH-1:0]           result_value,
    output logic [1:0]                      status,
    output logic [$clog2(DEPTH+1)-1:0]      entry_count,
    output logic [$clog2(DEPTH+1)-1:0]      removed_count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [31:0]            mask_reg, mask_next;
    logic [ITEM_WIDTH-1:0]  mask_w;
    logic [ITEM_WIDTH-1:0]  key_w;
    dqms_pkg::mem_ctl_t     mem_ctl;
    logic [AW-1:0]          mem_waddr;
    logic [ITEM_WIDTH-1:0]  mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [ITEM_WIDTH-1:0]  mem_rdata;

    // Register port: pready held high, register chosen by address bit 2.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == dqms_pkg::REG_IDX_MATCH_MASK) ? mask_reg : '0;

    always_comb
    begin
        mask_next = mask_reg;
        if (psel && penable && pwrite && (paddr[2] == dqms_pkg::REG_IDX_MATCH_MASK))
        begin
            mask_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= dqms_pkg::MATCH_MASK_RESET;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    // Item words and mask carry at most 32 significant bits.
    if (ITEM_WIDTH <= 32)
    begin : g_narrow
        assign mask_w = mask_reg[ITEM_WIDTH-1:0];
        assign key_w  = item_value;
    end
    else
    begin : g_wide
        assign mask_w = {{(ITEM_WIDTH-32){1'b0}}, mask_reg};
        assign key_w  = {{(ITEM_WIDTH-32){1'b0}}, item_value[31:0]};
    end

    // Request sequencer.
    dqms_ctrl #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH),
        .AW         (AW),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .key_in        (key_w),
        .mask_in       (mask_w),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_value  (result_value),
        .status        (status),
        .entry_count   (entry_count),
        .removed_count (removed_count),
        .mem_ctl       (mem_ctl),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    // Ring store.
    dqms_ram #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH),
        .AW         (AW)
    ) u_ram (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

### rtl/dqms_ram.sv
// Ring store of the queue: one write port and one read port, read data registered.
// Uses dqms_pkg for the access strobe struct.
module dqms_ram #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32,
    parameter int AW         = 4
) (
    input  logic                   clk,
    input  dqms_pkg::mem_ctl_t     ctl,
    input  logic [AW-1:0]          waddr,
    input  logic [ITEM_WIDTH-1:0]  wdata,
    input  logic [AW-1:0]          raddr,
    output logic [ITEM_WIDTH-1:0]  rdata
);

    logic [ITEM_WIDTH-1:0] mem [DEPTH];
    logic [ITEM_WIDTH-1:0] rdata_reg;

    // Write and registered read; the sequencer never reads the entry it writes.
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dqms_ctrl.sv
// Request sequencer of the queue: front index, count, store walk and result register.
// Uses dqms_pkg for codes, states and the store access struct; drives dqms_ram.
module dqms_ctrl #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32,
    parameter int AW         = 4,
    parameter int CNT_W      = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [3:0]             mode,
    input  logic [ITEM_WIDTH-1:0]  key_in,
    input  logic [ITEM_WIDTH-1:0]  mask_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [ITEM_WIDTH-1:0]  result_value,
    output logic [1:0]             status,
    output logic [CNT_W-1:0]       entry_count,
    output logic [CNT_W-1:0]       removed_count,
    output dqms_pkg::mem_ctl_t     mem_ctl,
    output logic [AW-1:0]          mem_waddr,
    output logic [ITEM_WIDTH-1:0]  mem_wdata,
    output logic [AW-1:0]          mem_raddr,
    input  logic [ITEM_WIDTH-1:0]  mem_rdata
);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [AW-1:0]    LAST_SLOT  = AW'(DEPTH - 1);

    dqms_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]          front_reg, front_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       rd_off_reg, rd_off_next;
    logic [CNT_W-1:0]       kept_reg, kept_next;
    logic [CNT_W-1:0]       removed_reg, removed_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic                   walk_rm_reg, walk_rm_next;
    logic [ITEM_WIDTH-1:0]  key_reg, key_next;
    logic [ITEM_WIDTH-1:0]  res_value_reg, res_value_next;
    dqms_pkg::status_t      res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ITEM_WIDTH-1:0]  out_value_reg, out_value_next;
    dqms_pkg::status_t      out_status_reg, out_status_next;
    logic [CNT_W-1:0]       out_count_reg, out_count_next;
    logic [CNT_W-1:0]       out_removed_reg, out_removed_next;

    logic is_full;
    logic is_empty;
    logic is_access;
    logic is_walk;
    logic hit;
    logic walk_end;
    logic out_free;
    logic [AW-1:0] front_dec;

    // Ring slot of an offset from the front; the sum stays below twice DEPTH.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Request decode shared by the next-state and output logic.
    assign is_full   = (count_reg == FULL_COUNT);
    assign is_empty  = (count_reg == '0);
    assign is_access = (mode == dqms_pkg::MODE_REMOVE_FRONT) ||
                       (mode == dqms_pkg::MODE_REMOVE_BACK)  ||
                       (mode == dqms_pkg::MODE_PEEK_FRONT)   ||
                       (mode == dqms_pkg::MODE_PEEK_BACK);
    assign is_walk   = (mode == dqms_pkg::MODE_FIND) ||
                       (mode == dqms_pkg::MODE_REMOVE_MATCH);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
    assign hit       = (((mem_rdata ^ key_reg) & mask_in) == '0);
    assign walk_end  = !rd_pend_reg && (rd_off_reg == count_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_stall = (state_reg != dqms_pkg::S_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dqms_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (is_access && !is_empty)
                    begin
                        state_next = dqms_pkg::S_RDATA;
                    end
                    else if (is_walk && !is_empty)
                    begin
                        state_next = dqms_pkg::S_WALK;
                    end
                    else
                    begin
                        state_next = dqms_pkg::S_DONE;
                    end
                end
            end
            dqms_pkg::S_RDATA:
            begin
                state_next = dqms_pkg::S_DONE;
            end
            dqms_pkg::S_WALK:
            begin
                if ((rd_pend_reg && !walk_rm_reg && hit) || walk_end)
                begin
                    state_next = dqms_pkg::S_DONE;
                end
            end
            dqms_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = dqms_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dqms_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, store accesses and result register.
    always_comb
    begin
        front_next       = front_reg;
        count_next       = count_reg;
        rd_off_next      = rd_off_reg;
        kept_next        = kept_reg;
        removed_next     = removed_reg;
        rd_pend_next     = rd_pend_reg;
        walk_rm_next     = walk_rm_reg;
        key_next         = key_reg;
        res_value_next   = res_value_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        out_removed_next = out_removed_reg;
        mem_ctl          = '0;
        mem_waddr        = '0;
        mem_wdata        = key_in;
        mem_raddr        = '0;

        case (state_reg)
            dqms_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next        = key_in;
                    walk_rm_next    = (mode == dqms_pkg::MODE_REMOVE_MATCH);
                    res_value_next  = '0;
                    res_status_next = dqms_pkg::ST_OK;
                    removed_next    = '0;
                    rd_pend_next    = 1'b0;
                    case (mode)
                        dqms_pkg::MODE_ADD_FRONT:
                        begin
                            if (is_full)
                            begin
                                res_status_next = dqms_pkg::ST_FULL;
                            end
                            else
                            begin
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                                mem_ctl.we = 1'b1;
                                mem_waddr  = front_dec;
                            end
                        end
                        dqms_pkg::MODE_ADD_BACK:
                        begin
                            if (is_full)
                            begin
                                res_status_next = dqms_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                mem_ctl.we = 1'b1;
                                mem_waddr  = slot_of(front_reg, count_reg);
                            end
                        end
                        dqms_pkg::MODE_REMOVE_FRONT,
                        dqms_pkg::MODE_PEEK_FRONT:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = dqms_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_ctl.re = 1'b1;
                                mem_raddr  = front_reg;
                                if (mode == dqms_pkg::MODE_REMOVE_FRONT)
                                begin
                                    front_next   = slot_of(front_reg, CNT_W'(1));
                                    count_next   = count_reg - 1'b1;
                                    removed_next = CNT_W'(1);
                                end
                            end
                        end
                        dqms_pkg::MODE_REMOVE_BACK,
                        dqms_pkg::MODE_PEEK_BACK:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = dqms_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_ctl.re = 1'b1;
                                mem_raddr  = slot_of(front_reg, count_reg - 1'b1);
                                if (mode == dqms_pkg::MODE_REMOVE_BACK)
                                begin
                                    count_next   = count_reg - 1'b1;
                                    removed_next = CNT_W'(1);
                                end
                            end
                        end
                        dqms_pkg::MODE_FIND,
                        dqms_pkg::MODE_REMOVE_MATCH:
                        begin
                            res_status_next = dqms_pkg::ST_NOMATCH;
                            kept_next       = '0;
                            if (!is_empty)
                            begin
                                mem_ctl.re   = 1'b1;
                                mem_raddr    = front_reg;
                                rd_off_next  = CNT_W'(1);
                                rd_pend_next = 1'b1;
                            end
                        end
                        dqms_pkg::MODE_CLEAR:
                        begin
                            removed_next = count_reg;
                            count_next   = '0;
                            front_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dqms_pkg::S_RDATA:
            begin
                res_value_next = mem_rdata;
            end
            dqms_pkg::S_WALK:
            begin
                // Judge the word read last cycle; compact survivors toward the front.
                if (rd_pend_reg)
                begin
                    if (!walk_rm_reg)
                    begin
                        if (hit)
                        begin
                            res_value_next  = mem_rdata;
                            res_status_next = dqms_pkg::ST_OK;
                        end
                    end
                    else if (hit)
                    begin
                        removed_next = removed_reg + 1'b1;
                    end
                    else
                    begin
                        mem_ctl.we = 1'b1;
                        mem_waddr  = slot_of(front_reg, kept_reg);
                        mem_wdata  = mem_rdata;
                        kept_next  = kept_reg + 1'b1;
                    end
                end
                // Issue the read of the next entry while any remain.
                if ((rd_off_reg != count_reg) && !(rd_pend_reg && !walk_rm_reg && hit))
                begin
                    mem_ctl.re   = 1'b1;
                    mem_raddr    = slot_of(front_reg, rd_off_reg);
                    rd_off_next  = rd_off_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                // All entries judged: settle the count after compaction.
                if (walk_end && walk_rm_reg)
                begin
                    count_next      = kept_reg;
                    res_status_next = (removed_reg == '0) ? dqms_pkg::ST_NOMATCH
                                                          : dqms_pkg::ST_OK;
                end
            end
            dqms_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_value_next   = res_value_reg;
                    out_status_next  = res_status_reg;
                    out_count_next   = count_reg;
                    out_removed_next = removed_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dqms_pkg::S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_off_reg      <= rd_off_next;
        kept_reg        <= kept_next;
        removed_reg     <= removed_next;
        walk_rm_reg     <= walk_rm_next;
        key_reg         <= key_next;
        res_value_reg   <= res_value_next;
        res_status_reg  <= res_status_next;
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
        out_removed_reg <= out_removed_next;
    end

    assign out_valid     = out_valid_reg;
    assign result_value  = out_value_reg;
    assign status        = out_status_reg;
    assign entry_count   = out_count_reg;
    assign removed_count = out_removed_reg;

    // The held count never exceeds the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("held count above depth");

    // A compaction write never lands on the entry being read in the same cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.we && mem_ctl.re) |-> (mem_waddr != mem_raddr))
        else $error("store read and write hit the same entry");

    // A finished result waits while the output word is still held.
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dqms_pkg::S_DONE && out_valid_reg && out_stall)
        |=> (state_reg == dqms_pkg::S_DONE))
        else $error("result left before the output word was taken");

    // Entries held plus entries removed never exceed the depth.
    a_out_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((CNT_W+1)'(out_count_reg) + (CNT_W+1)'(out_removed_reg)
                           <= (CNT_W+1)'(DEPTH)))
        else $error("reported counts exceed depth");

endmodule

### verif/deque_with_match_search_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for deque_with_match_search: directed and random requests,
// with a predicting scoreboard, random stalls on both sides and match mask changes.
// Depends on dqms_pkg and the deque_with_match_search RTL.
module tb;

    localparam int DEPTH = 16;
    localparam logic [3:0] MODE_FIRST_SPARE = 4'd9;
    localparam logic [3:0] MODE_LAST_SPARE  = 4'd15;
    localparam logic [2:0] MASK_ADDR        = {dqms_pkg::REG_IDX_MATCH_MASK, 2'b00};

    // One expected result word.
    typedef struct packed {
        logic [31:0]        value;
        dqms_pkg::status_t  state;
        logic [4:0]         count;
        logic [4:0]         dropped;
    } deque_result_t;

    // Shadow copy of the deque that predicts each result word and checks it.
    class deque_tracker;
        logic [31:0]   slots [DEPTH];
        logic [3:0]    head;
        logic [4:0]    held;
        logic [31:0]   mask;
        deque_result_t awaited [$];
        int            errors;

        function new();
            head = '0;
            held = '0;
            mask = dqms_pkg::MATCH_MASK_RESET;
            errors = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function logic [3:0] slot(logic [4:0] offset);
            return head + offset[3:0];
        endfunction

        function bit hit(logic [31:0] entry, logic [31:0] key);
            return ((entry ^ key) & mask) == '0;
        endfunction

        // Apply one accepted request to the shadow state and queue its result.
        function void take_request(logic [3:0] op, logic [31:0] key);
            deque_result_t r;
            logic [4:0]    kept;
            logic [31:0]   e;
            r.value = '0;
            r.state = dqms_pkg::ST_OK;
            r.dropped = '0;
            case (op)
                dqms_pkg::MODE_ADD_FRONT, dqms_pkg::MODE_ADD_BACK:
                begin
                    if (held == DEPTH)
                        r.state = dqms_pkg::ST_FULL;
                    else if (op == dqms_pkg::MODE_ADD_FRONT)
                    begin
                        head = head - 4'd1;
                        slots[head] = key;
                        held++;
                    end
                    else
                    begin
                        slots[slot(held)] = key;
                        held++;
                    end
                end
                dqms_pkg::MODE_REMOVE_FRONT, dqms_pkg::MODE_REMOVE_BACK,
                dqms_pkg::MODE_PEEK_FRONT, dqms_pkg::MODE_PEEK_BACK:
                begin
                    if (held == 0)
                        r.state = dqms_pkg::ST_EMPTY;
                    else
                    begin
                        if (op == dqms_pkg::MODE_REMOVE_FRONT ||
                            op == dqms_pkg::MODE_PEEK_FRONT)
                            r.value = slots[slot(0)];
                        else
                            r.value = slots[slot(held - 5'd1)];
                        if (op == dqms_pkg::MODE_REMOVE_FRONT)
                        begin
                            head = head + 4'd1;
                            held--;
                            r.dropped = 5'd1;
                        end
                        else if (op == dqms_pkg::MODE_REMOVE_BACK)
                        begin
                            held--;
                            r.dropped = 5'd1;
                        end
                    end
                end
                dqms_pkg::MODE_FIND:
                begin
                    r.state = dqms_pkg::ST_NOMATCH;
                    for (int k = 0; k < held; k++)
                    begin
                        e = slots[slot(k[4:0])];
                        if (hit(e, key))
                        begin
                            r.value = e;
                            r.state = dqms_pkg::ST_OK;
                            break;
                        end
                    end
                end
                dqms_pkg::MODE_REMOVE_MATCH:
                begin
                    // Survivors slide toward the front in their original order.
                    kept = '0;
                    for (int k = 0; k < held; k++)
                    begin
                        e = slots[slot(k[4:0])];
                        if (hit(e, key))
                            r.dropped++;
                        else
                        begin
                            slots[slot(kept)] = e;
                            kept++;
                        end
                    end
                    held = kept;
                    if (r.dropped == 0)
                        r.state = dqms_pkg::ST_NOMATCH;
                end
                dqms_pkg::MODE_CLEAR:
                begin
                    r.dropped = held;
                    held = '0;
                    head = '0;
                end
                default:
                begin
                end
            endcase
            r.count = held;
            awaited.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t: mismatch: %s", $time, msg);
        endtask

        // Compare one accepted result word with the oldest prediction.
        task match_result(logic [31:0] value, logic [1:0] state,
                          logic [4:0] count, logic [4:0] dropped);
            deque_result_t x;
            if (awaited.size() == 0)
                report("result word arrived with nothing awaited");
            else
            begin
                x = awaited.pop_front();
                if (value !== x.value)
                    report($sformatf("result_value %h, expected %h", value, x.value));
                if (state !== x.state)
                    report($sformatf("status %0d, expected %0d", state, x.state));
                if (count !== x.count)
                    report($sformatf("entry_count %0d, expected %0d", count, x.count));
                if (dropped !== x.dropped)
                    report($sformatf("removed_count %0d, expected %0d", dropped, x.dropped));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  mode = '0;
    logic [31:0] item_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic [31:0] result_value;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic [4:0]  removed_count;

    deque_tracker sb = new();
    logic [31:0]  key_pool [8];
    logic [31:0]  phase_masks [5];
    int           src_gap_max = 17;
    int           sink_gap_max = 17;

    deque_with_match_search dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Send one request word after a random gap and note it once accepted.
    task automatic send_request(input logic [3:0] op, input logic [31:0] key);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        mode <= op;
        item_value <= key;
        do @(posedge clk); while (in_stall);
        sb.take_request(op, key);
    endtask

    // Drop valid and wait until every predicted word has come back.
    task automatic finish_requests();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
    endtask

    // Write the match mask, then read it back.
    task automatic write_mask(input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= MASK_ADDR;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.mask = value;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
            sb.report($sformatf("match_mask read %h, expected %h", prdata, value));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Empty-queue cases, both ends, find hit and miss, duplicates and clear.
    task automatic directed_checks();
        send_request(dqms_pkg::MODE_REMOVE_FRONT, 32'h0);
        send_request(dqms_pkg::MODE_REMOVE_BACK, 32'h0);
        send_request(dqms_pkg::MODE_PEEK_FRONT, 32'h0);
        send_request(dqms_pkg::MODE_PEEK_BACK, 32'h0);
        send_request(dqms_pkg::MODE_FIND, 32'hFFFF_FFFF);
        send_request(dqms_pkg::MODE_REMOVE_MATCH, 32'h0);
        send_request(dqms_pkg::MODE_CLEAR, 32'h0);
        send_request(dqms_pkg::MODE_ADD_BACK, 32'hFFFF_FFFF);
        send_request(dqms_pkg::MODE_ADD_FRONT, 32'h0000_0000);
        send_request(dqms_pkg::MODE_ADD_BACK, 32'hA5A5_A5A5);
        send_request(dqms_pkg::MODE_ADD_FRONT, 32'h5A5A_5A5A);
        send_request(dqms_pkg::MODE_PEEK_FRONT, 32'h0);
        send_request(dqms_pkg::MODE_PEEK_BACK, 32'h0);
        send_request(dqms_pkg::MODE_FIND, 32'hA5A5_A5A5);
        send_request(dqms_pkg::MODE_FIND, 32'h1234_5678);
        send_request(dqms_pkg::MODE_ADD_BACK, 32'hA5A5_A5A5);
        send_request(dqms_pkg::MODE_REMOVE_MATCH, 32'hA5A5_A5A5);
        send_request(dqms_pkg::MODE_REMOVE_FRONT, 32'h0);
        send_request(dqms_pkg::MODE_REMOVE_BACK, 32'h0);
        send_request(MODE_LAST_SPARE, 32'hFFFF_FFFF);
        send_request(dqms_pkg::MODE_ADD_BACK, 32'h1234_5678);
        send_request(dqms_pkg::MODE_CLEAR, 32'h0);
    endtask

    // Weighted mode choice; a filling stretch favors adds so the queue fills up.
    function automatic logic [3:0] pick_mode(bit filling);
        int roll;
        int add_top;
        int rem_top;
        roll = $urandom_range(0, 99);
        add_top = filling ? 50 : 22;
        rem_top = filling ? 62 : 58;
        if (roll < add_top)
            return $urandom_range(0, 1) ? dqms_pkg::MODE_ADD_FRONT
                                        : dqms_pkg::MODE_ADD_BACK;
        if (roll < rem_top)
            return $urandom_range(0, 1) ? dqms_pkg::MODE_REMOVE_FRONT
                                        : dqms_pkg::MODE_REMOVE_BACK;
        if (roll < rem_top + 10)
            return $urandom_range(0, 1) ? dqms_pkg::MODE_PEEK_FRONT
                                        : dqms_pkg::MODE_PEEK_BACK;
        if (roll < rem_top + 20)
            return dqms_pkg::MODE_FIND;
        if (roll < 93)
            return dqms_pkg::MODE_REMOVE_MATCH;
        if (roll < 96)
            return dqms_pkg::MODE_CLEAR;
        return 4'($urandom_range(MODE_FIRST_SPARE, MODE_LAST_SPARE));
    endfunction

    // Mostly pool keys with random unmasked bits, so matches are common.
    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, 7)] ^ ($urandom & ~sb.mask);
        return $urandom;
    endfunction

    task automatic run_phase(input int items);
        bit filling;
        for (int i = 0; i < items; i++)
        begin
            if (i % 40 == 0)
            begin
                filling = $urandom_range(0, 1);
                src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
                sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            end
            send_request(pick_mode(filling), pick_key());
        end
    endtask

    // Result side: random stall per word, check on acceptance.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, sink_gap_max);
            repeat (gap)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.match_result(result_value, status, entry_count, removed_count);
        end
    end

    // Main sequence: reset, directed words, then random phases under several masks.
    initial
    begin
        foreach (key_pool[i]) key_pool[i] = $urandom;
        phase_masks = '{32'h0000_0000, 32'h0000_00FF, $urandom, 32'hFFFF_0000,
                        dqms_pkg::MATCH_MASK_RESET};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        directed_checks();
        finish_requests();
        foreach (phase_masks[i])
        begin
            write_mask(phase_masks[i]);
            run_phase(150);
            finish_requests();
        end
        repeat (25) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hang guard, far above the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
